>>> src/pyrgb_pkg.sv
`timescale 1ns / 1ps
// Shared types, template ROM data and fixed-point helpers for the palette converter.
package pyrgb_pkg;

  typedef logic signed [19:0] q_t;

  localparam q_t Q_MAX = 20'sd524287;
  localparam q_t Q_MIN = -20'sd524288;

  typedef enum logic {
    REG_LUMA_BLACK = 1'b0,
    REG_RGB_BLACK  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic signed [17:0] lbo;
    logic signed [17:0] rbo;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic pal;
    q_t   y;
    q_t   by;
    q_t   ry;
  } yuv_t;

  typedef struct packed {
    logic valid;
    q_t   r;
    q_t   g;
    q_t   b;
  } rgb_t;

  typedef struct packed {
    logic [15:0] y;
    logic [15:0] chb;
    logic [15:0] b;
    logic [15:0] a;
  } volt_t;

  typedef struct packed {
    logic [15:0] blank;
    logic [31:0] recip;
  } level_t;

  localparam longint BLANK_T0 = 770;
  localparam longint WHITE_T0 = 420;
  localparam longint BLANK_T1 = 725;
  localparam longint WHITE_T1 = 430;
  localparam longint SPAN_T0  = BLANK_T0 - WHITE_T0;
  localparam longint SPAN_T1  = BLANK_T1 - WHITE_T1;
  localparam logic [31:0] RECIP_T0 = 32'(((64'sd1 <<< 32) + SPAN_T0 / 2) / SPAN_T0);
  localparam logic [31:0] RECIP_T1 = 32'(((64'sd1 <<< 32) + SPAN_T1 / 2) / SPAN_T1);

  function automatic volt_t colour_volt(input logic [0:0] sel, input logic [3:0] col);
    volt_t v;
    case ({sel, col})
      5'd0:  v = '{16'd540, 16'd1500, 16'd1000, 16'd1000};
      5'd1:  v = '{16'd420, 16'd1500, 16'd1000, 16'd1500};
      5'd2:  v = '{16'd650, 16'd1500, 16'd2000, 16'd1500};
      5'd3:  v = '{16'd650, 16'd1500, 16'd1500, 16'd2000};
      5'd4:  v = '{16'd420, 16'd1500, 16'd1500, 16'd1500};
      5'd5:  v = '{16'd540, 16'd1500, 16'd1500, 16'd1000};
      5'd6:  v = '{16'd540, 16'd1500, 16'd2000, 16'd2000};
      5'd7:  v = '{16'd540, 16'd1500, 16'd1000, 16'd2000};
      5'd8:  v = '{16'd720, 16'd1500, 16'd1500, 16'd1500};
      5'd9:  v = '{16'd720, 16'd1500, 16'd1000, 16'd1000};
      5'd10: v = '{16'd720, 16'd1500, 16'd1000, 16'd2000};
      5'd11: v = '{16'd420, 16'd1500, 16'd1000, 16'd2000};
      5'd16: v = '{16'd525, 16'd1420, 16'd870,  16'd940};
      5'd17: v = '{16'd430, 16'd1400, 16'd860,  16'd1410};
      5'd18: v = '{16'd615, 16'd1380, 16'd1710, 16'd1380};
      5'd19: v = '{16'd615, 16'd1340, 16'd1280, 16'd1830};
      5'd20: v = '{16'd430, 16'd1350, 16'd1280, 16'd1350};
      5'd21: v = '{16'd525, 16'd1360, 16'd1290, 16'd960};
      5'd22: v = '{16'd525, 16'd1370, 16'd1700, 16'd1770};
      5'd23: v = '{16'd525, 16'd1400, 16'd850,  16'd1860};
      5'd24: v = '{16'd680, 16'd1350, 16'd1280, 16'd1350};
      5'd25: v = '{16'd680, 16'd1420, 16'd870,  16'd940};
      5'd26: v = '{16'd680, 16'd1400, 16'd850,  16'd1860};
      5'd27: v = '{16'd430, 16'd1400, 16'd850,  16'd1860};
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic level_t template_level(input logic [0:0] sel);
    level_t l;
    case (sel)
      1'b0: l = '{16'(BLANK_T0), RECIP_T0};
      1'b1: l = '{16'(BLANK_T1), RECIP_T1};
      default: l = '0;
    endcase
    return l;
  endfunction

  function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic q_t sat_q(input logic signed [63:0] v);
    q_t res;
    if (v > 64'(Q_MAX)) res = Q_MAX;
    else if (v < 64'(Q_MIN)) res = Q_MIN;
    else res = v[19:0];
    return res;
  endfunction

endpackage

>>> src/pyrgb_regs.sv
`timescale 1ns / 1ps
// Configuration registers behind the APB port: luma and RGB black offsets.
module pyrgb_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output pyrgb_pkg::cfg_t    cfg
);

  logic               wr;
  logic signed [17:0] lbo;
  logic signed [17:0] rbo;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign cfg    = '{lbo, rbo};

  always_ff @(posedge clk) begin
    if (rst) begin
      lbo <= '0;
      rbo <= '0;
    end else if (wr) begin
      case (pyrgb_pkg::reg_idx_t'(paddr[2]))
        pyrgb_pkg::REG_LUMA_BLACK: lbo <= pwdata[17:0];
        pyrgb_pkg::REG_RGB_BLACK:  rbo <= pwdata[17:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (pyrgb_pkg::reg_idx_t'(paddr[2]))
      pyrgb_pkg::REG_LUMA_BLACK: prdata = {{14{lbo[17]}}, lbo};
      pyrgb_pkg::REG_RGB_BLACK:  prdata = {{14{rbo[17]}}, rbo};
      default:                   prdata = '0;
    endcase
  end

  a_luma_write: assert property (@(posedge clk) disable iff (rst)
    (wr && paddr[2] == pyrgb_pkg::REG_LUMA_BLACK) |=> (cfg.lbo == $past(pwdata[17:0])))
    else $error("luma offset write lost");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !wr |=> $stable(cfg))
    else $error("offsets changed without a write");

endmodule

>>> src/pyrgb_decode.sv
`timescale 1ns / 1ps
// Template ROM lookup, luma normalization and colour difference scaling.
module pyrgb_decode #(
  parameter int NUM_TEMPLATES = 2,
  parameter int NUM_COLOURS   = 12
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [0:0]      palette_select,
  input  logic [3:0]      colour,
  input  logic            mode,
  input  pyrgb_pkg::cfg_t cfg,
  output pyrgb_pkg::yuv_t yuv
);

  localparam logic [0:0] SEL_LAST = 1'(NUM_TEMPLATES - 1);
  localparam logic [3:0] COL_LAST = 4'(NUM_COLOURS - 1);
  localparam logic signed [23:0] K_MV = 24'sd4294967;

  logic [0:0]               sel_c;
  logic [3:0]               col_c;
  pyrgb_pkg::volt_t         vt;
  pyrgb_pkg::level_t        lv;

  logic                     d1_valid;
  logic                     d1_pal;
  logic signed [16:0]       d1_dy;
  logic signed [16:0]       d1_db;
  logic signed [16:0]       d1_da;
  logic [31:0]              d1_recip;

  logic                     d2_valid;
  logic                     d2_pal;
  logic signed [49:0]       d2_py;
  logic signed [40:0]       d2_pb;
  logic signed [40:0]       d2_pa;

  logic                     d3_valid;
  logic                     d3_pal;
  pyrgb_pkg::q_t            d3_y;
  pyrgb_pkg::q_t            d3_by;
  pyrgb_pkg::q_t            d3_ry;

  always_comb begin
    sel_c = (32'(palette_select) >= NUM_TEMPLATES) ? SEL_LAST : palette_select;
    col_c = (32'(colour) >= NUM_COLOURS) ? COL_LAST : colour;
    vt    = pyrgb_pkg::colour_volt(sel_c, col_c);
    lv    = pyrgb_pkg::template_level(sel_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_valid <= 1'b0;
      d2_valid <= 1'b0;
      d3_valid <= 1'b0;
    end else begin
      d1_valid <= accept;
      d2_valid <= d1_valid;
      d3_valid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    d1_pal   <= mode;
    d1_dy    <= $signed({1'b0, lv.blank}) - $signed({1'b0, vt.y});
    d1_db    <= $signed({1'b0, vt.b}) - $signed({1'b0, vt.chb});
    d1_da    <= $signed({1'b0, vt.a}) - $signed({1'b0, vt.chb});
    d1_recip <= lv.recip;

    d2_pal   <= d1_pal;
    d2_py    <= d1_dy * $signed({1'b0, d1_recip});
    d2_pb    <= d1_db * K_MV;
    d2_pa    <= d1_da * K_MV;

    d3_pal   <= d2_pal;
    d3_y     <= pyrgb_pkg::sat_q(64'(cfg.lbo)
                + 64'(pyrgb_pkg::sat_q(pyrgb_pkg::rnd16(64'(d2_py)))));
    d3_by    <= pyrgb_pkg::sat_q(pyrgb_pkg::rnd16(64'(d2_pb)));
    d3_ry    <= pyrgb_pkg::sat_q(pyrgb_pkg::rnd16(64'(d2_pa)));
  end

  assign yuv = '{d3_valid, d3_pal, d3_y, d3_by, d3_ry};

endmodule

>>> src/pyrgb_matrix.sv
`timescale 1ns / 1ps
// PAL YUV / NTSC YIQ matrices from colour differences to gamma-encoded RGB.
module pyrgb_matrix (
  input  logic            clk,
  input  logic            rst,
  input  pyrgb_pkg::yuv_t yuv,
  output pyrgb_pkg::rgb_t rgb
);

  localparam logic signed [17:0] KNT [4] = '{-18'sd17695, 18'sd48497, 18'sd26870, 18'sd31457};
  localparam logic signed [17:0] KPAL [4] = '{18'sd32309, 18'sd0, 18'sd0, 18'sd57475};
  localparam logic signed [18:0] CNT [6] = '{19'sd62652, 19'sd40698, 19'sd17826,
                                             19'sd42402, 19'sd72417, 19'sd111542};
  localparam logic signed [18:0] CPAL [6] = '{19'sd0, 19'sd74711, 19'sd25952,
                                              19'sd38076, 19'sd132973, 19'sd0};
  localparam logic SUB_NT [6]  = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
  localparam logic SUB_PAL [6] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};

  logic                   m1_valid;
  logic                   m1_pal;
  pyrgb_pkg::q_t          m1_y;
  logic signed [37:0]     m1_p [4];

  logic                   m2_valid;
  logic                   m2_pal;
  pyrgb_pkg::q_t          m2_y;
  pyrgb_pkg::q_t          m2_c1;
  pyrgb_pkg::q_t          m2_c2;

  logic                   m3_valid;
  logic                   m3_pal;
  pyrgb_pkg::q_t          m3_y;
  logic signed [38:0]     m3_p [6];

  logic                   m4_valid;
  pyrgb_pkg::q_t          m4_ch [3];
  pyrgb_pkg::q_t          m4_ch_next [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
      m3_valid <= 1'b0;
      m4_valid <= 1'b0;
    end else begin
      m1_valid <= yuv.valid;
      m2_valid <= m1_valid;
      m3_valid <= m2_valid;
      m4_valid <= m3_valid;
    end
  end

  always_ff @(posedge clk) begin
    m1_pal  <= yuv.pal;
    m1_y    <= yuv.y;
    m1_p[0] <= yuv.by * (yuv.pal ? KPAL[0] : KNT[0]);
    m1_p[1] <= yuv.ry * (yuv.pal ? KPAL[1] : KNT[1]);
    m1_p[2] <= yuv.by * (yuv.pal ? KPAL[2] : KNT[2]);
    m1_p[3] <= yuv.ry * (yuv.pal ? KPAL[3] : KNT[3]);

    m2_pal  <= m1_pal;
    m2_y    <= m1_y;
    m2_c1   <= pyrgb_pkg::sat_q(pyrgb_pkg::rnd16(64'(m1_p[0]))
               + pyrgb_pkg::rnd16(64'(m1_p[1])));
    m2_c2   <= pyrgb_pkg::sat_q(pyrgb_pkg::rnd16(64'(m1_p[2]))
               + pyrgb_pkg::rnd16(64'(m1_p[3])));

    m3_pal  <= m2_pal;
    m3_y    <= m2_y;
    for (int c = 0; c < 3; c++) begin
      m3_p[2*c]   <= m2_c1 * (m2_pal ? CPAL[2*c] : CNT[2*c]);
      m3_p[2*c+1] <= m2_c2 * (m2_pal ? CPAL[2*c+1] : CNT[2*c+1]);
    end

    for (int c = 0; c < 3; c++) begin
      m4_ch[c] <= m4_ch_next[c];
    end
  end

  always_comb begin
    logic signed [63:0] t0;
    logic signed [63:0] t1;
    logic               s0;
    logic               s1;
    for (int c = 0; c < 3; c++) begin
      t0 = pyrgb_pkg::rnd16(64'(m3_p[2*c]));
      t1 = pyrgb_pkg::rnd16(64'(m3_p[2*c+1]));
      s0 = m3_pal ? SUB_PAL[2*c] : SUB_NT[2*c];
      s1 = m3_pal ? SUB_PAL[2*c+1] : SUB_NT[2*c+1];
      m4_ch_next[c] = pyrgb_pkg::sat_q(64'(m3_y) + (s0 ? -t0 : t0) + (s1 ? -t1 : t1));
    end
  end

  assign rgb = '{m4_valid, m4_ch[0], m4_ch[1], m4_ch[2]};

endmodule

>>> src/pyrgb_gamma.sv
`timescale 1ns / 1ps
// Inverse transfer curve per channel, black offset and output clamp.
module pyrgb_gamma #(
  parameter int GAMMA_INDEX_BITS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  pyrgb_pkg::rgb_t    rgb,
  input  logic signed [17:0] rbo,
  output logic               done,
  output logic [15:0]        red,
  output logic [15:0]        green,
  output logic [15:0]        blue
);

  localparam int SIZE = 1 << GAMMA_INDEX_BITS;
  localparam int FRAC = 16 - GAMMA_INDEX_BITS;

  localparam logic signed [16:0] LIN_K   = 17'sd14564;
  localparam logic signed [20:0] T_OFS   = 21'sd6488;
  localparam logic signed [17:0] T_K     = 18'sd59632;
  localparam pyrgb_pkg::q_t      LIN_MAX = 20'sd5308;
  localparam logic [16:0]        ONE     = 17'd65536;

  typedef logic [15:0] gamma_rom_t [SIZE];

  function automatic gamma_rom_t build_gamma();
    gamma_rom_t        tab;
    longint unsigned   x;
    longint unsigned   goal;
    longint unsigned   r;
    longint unsigned   rb;
    for (int k = 0; k < SIZE; k++) begin
      x = 64'(k) << FRAC;
      goal = x << 44;
      r = 0;
      for (int b = 11; b >= 0; b--) begin
        rb = r | (64'd1 << b);
        if (rb * rb * rb * rb * rb <= goal) r = rb;
      end
      tab[k] = 16'((((x * x) >> 16) * r) >> 12);
    end
    return tab;
  endfunction

  localparam gamma_rom_t GAMMA_ROM = build_gamma();

  pyrgb_pkg::q_t              vin [3];

  logic                       g1_valid;
  logic signed [36:0]         g1_lin_p [3];
  logic signed [38:0]         g1_t_p [3];
  logic                       g1_lo [3];

  logic signed [63:0]         t_rnd [3];
  logic [GAMMA_INDEX_BITS-1:0] idx [3];

  logic                       g2_valid;
  logic [15:0]                g2_e0 [3];
  logic [15:0]                g2_e1 [3];
  logic                       g2_last [3];
  logic [FRAC-1:0]            g2_frac [3];
  logic signed [17:0]         g2_lin [3];
  logic                       g2_lo [3];
  logic                       g2_hi [3];

  logic [16:0]                e0x [3];
  logic [16:0]                e1x [3];
  logic [FRAC+16:0]           ip [3];
  logic signed [17:0]         tv_next [3];

  logic                       g3_valid;
  logic signed [17:0]         g3_tv [3];
  logic                       g3_lo [3];

  logic signed [18:0]         osum [3];
  logic [15:0]                out_next [3];
  logic                       g4_valid;
  logic [15:0]                g4_out [3];

  assign vin[0] = rgb.r;
  assign vin[1] = rgb.g;
  assign vin[2] = rgb.b;

  always_ff @(posedge clk) begin
    if (rst) begin
      g1_valid <= 1'b0;
      g2_valid <= 1'b0;
      g3_valid <= 1'b0;
      g4_valid <= 1'b0;
    end else begin
      g1_valid <= rgb.valid;
      g2_valid <= g1_valid;
      g3_valid <= g2_valid;
      g4_valid <= g3_valid;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      t_rnd[c] = pyrgb_pkg::rnd16(64'(g1_t_p[c]));
      idx[c]   = t_rnd[c][15:FRAC];
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      e0x[c] = {1'b0, g2_e0[c]};
      e1x[c] = g2_last[c] ? ONE : {1'b0, g2_e1[c]};
      if (e1x[c] < e0x[c]) e1x[c] = e0x[c];
      ip[c] = {{FRAC{1'b0}}, 17'(e1x[c] - e0x[c])} * {17'd0, g2_frac[c]};
      if (g2_lo[c]) tv_next[c] = g2_lin[c];
      else if (g2_hi[c]) tv_next[c] = $signed({1'b0, ONE});
      else tv_next[c] = $signed({1'b0, 17'(e0x[c] + 17'(ip[c] >> FRAC))});
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      osum[c] = 19'(g3_tv[c]) + 19'(rbo);
      if (osum[c] < 0) out_next[c] = '0;
      else if (osum[c] >= 19'sd65535) out_next[c] = 16'hFFFF;
      else out_next[c] = osum[c][15:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      g1_lin_p[c] <= vin[c] * LIN_K;
      g1_t_p[c]   <= (21'(vin[c]) + T_OFS) * T_K;
      g1_lo[c]    <= vin[c] <= LIN_MAX;

      g2_e0[c]    <= GAMMA_ROM[idx[c]];
      g2_e1[c]    <= GAMMA_ROM[idx[c] + 1'b1];
      g2_last[c]  <= &idx[c];
      g2_frac[c]  <= t_rnd[c][FRAC-1:0];
      g2_lin[c]   <= 18'(pyrgb_pkg::rnd16(64'(g1_lin_p[c])));
      g2_lo[c]    <= g1_lo[c];
      g2_hi[c]    <= t_rnd[c] >= 64'sd65536;

      g3_tv[c]    <= tv_next[c];
      g3_lo[c]    <= g2_lo[c];

      g4_out[c]   <= out_next[c];
    end
  end

  assign done  = g4_valid;
  assign red   = g4_out[0];
  assign green = g4_out[1];
  assign blue  = g4_out[2];

  a_curve_range: assert property (@(posedge clk) disable iff (rst)
    (g3_valid && !g3_lo[0]) |-> (g3_tv[0] >= 0 && g3_tv[0] <= $signed({1'b0, ONE})))
    else $error("interpolated curve value out of range");

endmodule

>>> src/palette_yuv_yiq_to_linear_rgb.sv
`timescale 1ns / 1ps
// Top level of the palette colour to linear RGB converter.
// Takes one palette colour per clock: an item is accepted when start is high and busy is
// low, and busy is high only while rst is held. The result appears on red, green and blue
// with done high for one cycle, through the eleven register stages of the pipeline:
// three for the template ROM lookup and luma / colour difference scaling, four for
// the two matrix products, and four for the transfer curve, whose gamma ROM is read
// through a registered dual-read port per channel. Results leave in accept order and
// cannot be held off. Offsets (0x0 luma black, 0x4 RGB black, 18-bit signed) are to be
// written by the user over APB only while no item is in flight; the block does not check.
module palette_yuv_yiq_to_linear_rgb #(
  parameter int NUM_TEMPLATES    = 2,
  parameter int NUM_COLOURS      = 12,
  parameter int GAMMA_INDEX_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [0:0]  palette_select,
  input  logic [3:0]  colour,
  input  logic        mode,
  output logic        done,
  output logic [15:0] red,
  output logic [15:0] green,
  output logic [15:0] blue,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int LATENCY = 11;

  logic            accept;
  pyrgb_pkg::cfg_t cfg;
  pyrgb_pkg::yuv_t yuv;
  pyrgb_pkg::rgb_t rgb;

  assign busy   = rst;
  assign accept = start && !busy;

  pyrgb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pyrgb_decode #(
    .NUM_TEMPLATES (NUM_TEMPLATES),
    .NUM_COLOURS   (NUM_COLOURS)
  ) u_decode (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .palette_select (palette_select),
    .colour         (colour),
    .mode           (mode),
    .cfg            (cfg),
    .yuv            (yuv)
  );

  pyrgb_matrix u_matrix (
    .clk (clk),
    .rst (rst),
    .yuv (yuv),
    .rgb (rgb)
  );

  pyrgb_gamma #(
    .GAMMA_INDEX_BITS (GAMMA_INDEX_BITS)
  ) u_gamma (
    .clk   (clk),
    .rst   (rst),
    .rgb   (rgb),
    .rbo   (cfg.rbo),
    .done  (done),
    .red   (red),
    .green (green),
    .blue  (blue)
  );

  a_word_out: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("accepted word produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result without an accepted word");

endmodule

>>> sim/palette_yuv_yiq_to_linear_rgb_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the palette colour to linear RGB converter.
module palette_yuv_yiq_to_linear_rgb_tb;

  localparam logic MODE_NTSC = 1'b0;
  localparam logic MODE_PAL  = 1'b1;
  localparam int NUM_COLOURS = 12;
  localparam int LUT_BITS    = 10;
  localparam int LUT_SIZE    = 1 << LUT_BITS;
  localparam int FRAC_BITS   = 16 - LUT_BITS;
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic [0:0] sel;
    logic [3:0] col;
    logic       mode;
  } swatch_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } linear_rgb_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [0:0]  palette_select = '0;
  logic [3:0]  colour = '0;
  logic        mode = MODE_NTSC;
  logic        done;
  logic [15:0] red;
  logic [15:0] green;
  logic [15:0] blue;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  swatch_t     swatch_queue[$];
  linear_rgb_t rgb_expected_q[$];
  swatch_t     cur_swatch;
  int          gap_cycles = 0;
  int          stall_cycles = 0;
  int          mismatches = 0;
  bit          calm = 1'b0;
  int          gamma_lut[LUT_SIZE];
  logic signed [17:0] luma_offset = '0;
  logic signed [17:0] rgb_offset = '0;

  palette_yuv_yiq_to_linear_rgb uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .palette_select(palette_select), .colour(colour), .mode(mode),
    .done(done), .red(red), .green(green), .blue(blue),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // {y, chb, b, a} in mV
  function automatic logic [63:0] volt_entry(int idx);
    logic [63:0] e;
    case (idx)
      0:  e = {16'd540, 16'd1500, 16'd1000, 16'd1000};
      1:  e = {16'd420, 16'd1500, 16'd1000, 16'd1500};
      2:  e = {16'd650, 16'd1500, 16'd2000, 16'd1500};
      3:  e = {16'd650, 16'd1500, 16'd1500, 16'd2000};
      4:  e = {16'd420, 16'd1500, 16'd1500, 16'd1500};
      5:  e = {16'd540, 16'd1500, 16'd1500, 16'd1000};
      6:  e = {16'd540, 16'd1500, 16'd2000, 16'd2000};
      7:  e = {16'd540, 16'd1500, 16'd1000, 16'd2000};
      8:  e = {16'd720, 16'd1500, 16'd1500, 16'd1500};
      9:  e = {16'd720, 16'd1500, 16'd1000, 16'd1000};
      10: e = {16'd720, 16'd1500, 16'd1000, 16'd2000};
      11: e = {16'd420, 16'd1500, 16'd1000, 16'd2000};
      12: e = {16'd525, 16'd1420, 16'd870,  16'd940};
      13: e = {16'd430, 16'd1400, 16'd860,  16'd1410};
      14: e = {16'd615, 16'd1380, 16'd1710, 16'd1380};
      15: e = {16'd615, 16'd1340, 16'd1280, 16'd1830};
      16: e = {16'd430, 16'd1350, 16'd1280, 16'd1350};
      17: e = {16'd525, 16'd1360, 16'd1290, 16'd960};
      18: e = {16'd525, 16'd1370, 16'd1700, 16'd1770};
      19: e = {16'd525, 16'd1400, 16'd850,  16'd1860};
      20: e = {16'd680, 16'd1350, 16'd1280, 16'd1350};
      21: e = {16'd680, 16'd1420, 16'd870,  16'd940};
      22: e = {16'd680, 16'd1400, 16'd850,  16'd1860};
      default: e = {16'd430, 16'd1400, 16'd850, 16'd1860};
    endcase
    return e;
  endfunction

  function automatic longint clip_q(longint v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return v;
  endfunction

  function automatic longint mul_round(longint a, longint k);
    return (a * k + 32768) >>> 16;
  endfunction

  function automatic void build_gamma_lut();
    longint unsigned x, goal, r, bitv, p;
    for (int k = 0; k < LUT_SIZE; k++) begin
      x = longint'(k) << FRAC_BITS;
      goal = x << 44;
      r = 0;
      for (bitv = 2048; bitv != 0; bitv = bitv >> 1) begin
        p = (r | bitv) * (r | bitv) * (r | bitv) * (r | bitv) * (r | bitv);
        if (p <= goal) r = r | bitv;
      end
      gamma_lut[k] = int'((((x * x) >> 16) * r) >> 12);
    end
  endfunction

  function automatic longint inv_gamma(longint v);
    longint t, e0, e1, f;
    int idx;
    if (v <= 5308) return mul_round(v, 14564);
    t = mul_round(v + 6488, 59632);
    if (t >= 65536) return 65536;
    idx = int'(t >>> FRAC_BITS);
    f = t & ((64'sd1 <<< FRAC_BITS) - 1);
    e0 = gamma_lut[idx];
    e1 = (idx + 1 < LUT_SIZE) ? gamma_lut[idx + 1] : 65536;
    if (e1 < e0) e1 = e0;
    return e0 + (((e1 - e0) * f) >>> FRAC_BITS);
  endfunction

  function automatic logic [15:0] to_linear(longint v);
    longint o;
    o = clip_q(inv_gamma(v) + longint'(rgb_offset));
    if (o < 0) o = 0;
    if (o > 65535) o = 65535;
    return 16'(o);
  endfunction

  function automatic linear_rgb_t predict_linear_rgb(swatch_t s);
    linear_rgb_t res;
    logic [63:0] e;
    longint ymv, chb, bv, av, blank, white, span, recip;
    longint y, by, ry, u, v, i, q, r, g, b;
    int col;
    col = (s.col >= NUM_COLOURS) ? NUM_COLOURS - 1 : int'(s.col);
    e = volt_entry(int'(s.sel) * NUM_COLOURS + col);
    ymv = longint'(e[63:48]);
    chb = longint'(e[47:32]);
    bv = longint'(e[31:16]);
    av = longint'(e[15:0]);
    blank = s.sel ? 725 : 770;
    white = s.sel ? 430 : 420;
    span = blank - white;
    recip = ((64'sd1 <<< 32) + span / 2) / span;
    y = clip_q(longint'(luma_offset) + clip_q(mul_round(blank - ymv, recip)));
    by = clip_q(mul_round(bv - chb, 4294967));
    ry = clip_q(mul_round(av - chb, 4294967));
    if (s.mode == MODE_PAL) begin
      u = clip_q(mul_round(by, 32309));
      v = clip_q(mul_round(ry, 57475));
      r = clip_q(y + mul_round(v, 74711));
      g = clip_q(y - mul_round(u, 25952) - mul_round(v, 38076));
      b = clip_q(y + mul_round(u, 132973));
    end else begin
      i = clip_q(mul_round(by, -17695) + mul_round(ry, 48497));
      q = clip_q(mul_round(by, 26870) + mul_round(ry, 31457));
      r = clip_q(y + mul_round(i, 62652) + mul_round(q, 40698));
      g = clip_q(y - mul_round(i, 17826) - mul_round(q, 42402));
      b = clip_q(y - mul_round(i, 72417) + mul_round(q, 111542));
    end
    res.red = to_linear(r);
    res.green = to_linear(g);
    res.blue = to_linear(b);
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_cycles <= 0;
    end else begin
      if (start && !busy) rgb_expected_q.push_back(predict_linear_rgb(cur_swatch));
      if (!start || !busy) begin
        if (gap_cycles > 0) begin
          start <= 1'b0;
          gap_cycles <= gap_cycles - 1;
        end else if (swatch_queue.size() > 0) begin
          cur_swatch = swatch_queue.pop_front();
          start <= 1'b1;
          palette_select <= cur_swatch.sel;
          colour <= cur_swatch.col;
          mode <= cur_swatch.mode;
          if (!calm && $urandom_range(5, 0) == 0) gap_cycles <= $urandom_range(11, 1);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    linear_rgb_t want;
    if (!rst && done) begin
      if (rgb_expected_q.size() == 0) begin
        $error("unexpected word: red %0d green %0d blue %0d", red, green, blue);
        mismatches++;
      end else begin
        want = rgb_expected_q.pop_front();
        if (red !== want.red) begin
          $error("red: expected %0d, actual %0d", want.red, red);
          mismatches++;
        end
        if (green !== want.green) begin
          $error("green: expected %0d, actual %0d", want.green, green);
          mismatches++;
        end
        if (blue !== want.blue) begin
          $error("blue: expected %0d, actual %0d", want.blue, blue);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      luma_offset <= '0;
      rgb_offset <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (pyrgb_pkg::reg_idx_t'(paddr[2]))
        pyrgb_pkg::REG_LUMA_BLACK: luma_offset <= pwdata[17:0];
        pyrgb_pkg::REG_RGB_BLACK:  rgb_offset <= pwdata[17:0];
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_reg(pyrgb_pkg::reg_idx_t idx, int value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain_words();
    do @(negedge clk);
    while (swatch_queue.size() != 0 || start || rgb_expected_q.size() != 0);
  endtask

  task automatic load_random(int count);
    swatch_t s;
    @(negedge clk);
    for (int n = 0; n < count; n++) begin
      s.sel = 1'($urandom_range(1, 0));
      s.col = 4'($urandom_range(15, 0));
      s.mode = 1'($urandom_range(1, 0));
      swatch_queue.push_back(s);
    end
  endtask

  initial begin
    swatch_t s;
    int lbo, rbo;
    build_gamma_lut();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    for (int c = 0; c < 16; c++) begin
      s.sel = 1'(c);
      s.col = 4'(c);
      s.mode = 1'(c >> 1);
      swatch_queue.push_back(s);
    end
    swatch_queue.push_back('{sel: 1'b0, col: 4'd15, mode: MODE_NTSC});
    swatch_queue.push_back('{sel: 1'b1, col: 4'd15, mode: MODE_PAL});
    swatch_queue.push_back('{sel: 1'b1, col: 4'd0, mode: MODE_PAL});
    swatch_queue.push_back('{sel: 1'b0, col: 4'd0, mode: MODE_NTSC});
    drain_words();

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin lbo = -65536; rbo = 65536; end
        1: begin lbo = 65536; rbo = -65536; end
        2: begin lbo = -65536; rbo = -65536; end
        6: begin lbo = 0; rbo = 0; end
        default: begin
          lbo = int'($urandom_range(131072, 0)) - 65536;
          rbo = int'($urandom_range(131072, 0)) - 65536;
        end
      endcase
      write_reg(pyrgb_pkg::REG_LUMA_BLACK, lbo);
      write_reg(pyrgb_pkg::REG_RGB_BLACK, rbo);
      if (p == 6) calm = 1'b1;
      load_random((p == 6) ? 90 : 60);
      drain_words();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && rgb_expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
